/* hw/rtl/sge_pkg.sv */
// Shared types and constants for the 3x3 gradient energy stencil.
// No dependencies; every other file of the block but sge_checker imports this package.
package sge_pkg;

    // Input operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Register values after reset.
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd1024;

    // Stencil weights, unsigned Q0.16.
    localparam logic [15:0] W_B = 16'd1892;
    localparam logic [15:0] W_A = 16'd34054;
    localparam logic [15:0] W_P = 16'd28984;
    localparam logic [15:0] W_M = 16'd36552;

    // Saturation limits of the 18-bit gradient outputs.
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    // Job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] level;
    } t_qstat;

    // Width of one packed job: last flag, three pre-summed terms and four samples.
    function automatic int job_width(input int sample_bits);
        job_width = 1 + 3 * (sample_bits + 3) + 4 * sample_bits;
    endfunction

endpackage

/* hw/rtl/stencil_gradient_energy_3x3.sv */
// Top level of the streaming 3x3 gradient energy stencil.
// Depends on sge_pkg, sge_front, sge_queue and sge_back.
//
// Channel      Direction  Handshake                 Payload
// input item   in         i_in_valid / o_in_ready   i_op, i_sample
// result item  out        o_out_valid / i_out_ready o_grad_first, o_grad_second,
//                                                   o_energy, o_last_pixel
// config write in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One input transaction is taken per clock while the result side keeps up; a
// result is offered at the output once the transaction that causes it has been
// registered in the front part, written into the job queue and passed through
// the back part's product, sum, saturation, square and output registers. The pace
// is set by the line store, which has one read and one write port and is read and
// written once per sample, and by the fully pipelined back part.
// Reset is synchronous and active low; it clears the control state and the
// sample window, while the line store keeps whatever it held.
// A stall on the result side freezes the back part; the four-entry job queue
// then fills and input ready falls until space is free again.
module stencil_gradient_energy_3x3 import sge_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic signed [15:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_grad_first,
    output logic signed [17:0] o_grad_second,
    output logic [35:0]        o_energy,
    output logic               o_last_pixel,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int JOB_W = job_width(SAMPLE_BITS);

    // The front part owns the raster position and window; it pushes one job for
    // every transaction that yields a result. Jobs for border pixels carry zeros.
    logic             push;
    logic             pop;
    logic [JOB_W-1:0] push_job;
    logic [JOB_W-1:0] head_job;
    t_qstat           qstat;

    sge_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_job       (push_job)
    );

    sge_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_stat  (qstat)
    );

    // The back part turns each job into the two gradients and their energy.
    sge_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_grad_first  (o_grad_first),
        .o_grad_second (o_grad_second),
        .o_energy      (o_energy),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

/* hw/rtl/sge_queue.sv */
// Small job queue that decouples the front and back parts of the stencil.
// Depends on sge_pkg for the queue depth and the status struct.
module sge_queue import sge_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_qstat           o_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]  r_slot [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [QCNT_W-1:0] r_level;

    assign o_data       = r_slot[r_rd];
    assign o_stat.empty = (r_level == '0);
    assign o_stat.level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

/* hw/rtl/sge_front.sv */
// Front part: configuration, raster position, line store and window.
// Depends on sge_pkg; feeds jobs into sge_queue.
module sge_front import sge_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [15:0]                  i_sample,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    input  t_qstat                              i_qstat,
    output logic                                o_push,
    output logic [job_width(SAMPLE_BITS)-1:0]   o_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SB = SAMPLE_BITS;
    localparam int SW = SAMPLE_BITS + 3;

    typedef struct packed {
        logic                 last;
        logic signed [SW-1:0] corners;
        logic signed [SW-1:0] d1;
        logic signed [SW-1:0] d2;
        logic signed [SB-1:0] mid;
        logic signed [SB-1:0] lm;
        logic signed [SB-1:0] cd;
        logic signed [SB-1:0] cu;
    } t_job;

    logic [10:0]          r_width;
    logic [15:0]          r_height;
    logic [CW-1:0]        r_col;
    logic [15:0]          r_row;
    logic                 r_all_in;
    logic                 r_emit;

    logic [WW-1:0]        w_eff;
    logic [WW-1:0]        w_last;
    logic [15:0]          h_eff;
    logic [15:0]          h_last;
    logic [15:0]          h_next;
    logic                 col_end;

    logic                 acc;
    logic                 phase_smp;
    logic                 is_smp;
    logic                 proc;
    logic                 last_now;
    logic                 hazard;
    logic signed [SB-1:0] w_dn;

    logic [2*SB-1:0]      mem [MAX_WIDTH];
    logic [2*SB-1:0]      r_mem_q;

    logic                 r_f1_v;
    logic                 r_f1_smp;
    logic signed [SB-1:0] r_f1_dn;
    logic [CW-1:0]        r_f1_col;
    logic                 r_f1_int;
    logic                 r_f1_emit;
    logic                 r_f1_last;
    logic                 r_f1_fwd;
    logic [2*SB-1:0]      r_fwd_pair;

    logic [2*SB-1:0]      f1_pair;
    logic signed [SB-1:0] f1_up;
    logic signed [SB-1:0] f1_mid;
    logic signed [SB-1:0] r_win [6];
    t_job                 job;

    // Effective frame size.
    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
    end

    assign w_last  = w_eff - WW'(1);
    assign h_eff   = (r_height == 16'd0) ? 16'd1 : r_height;
    assign h_last  = h_eff - 16'd1;
    assign h_next  = h_eff + 16'd1;
    assign col_end = (WW'(r_col) == w_last);

    generate
        if (SAMPLE_BITS <= 16) begin : g_narrow
            assign w_dn = $signed(i_sample[SAMPLE_BITS-1:0]);
        end else begin : g_wide
            assign w_dn = $signed({{(SAMPLE_BITS - 16){1'b0}}, i_sample});
        end
    endgenerate

    // Two transactions can be in flight ahead of the queue: the one in the
    // second stage and the one being accepted.
    assign o_in_ready = (i_qstat.level + QCNT_W'(r_f1_v)) < QCNT_W'(QUEUE_DEPTH);

    assign acc       = i_in_valid && o_in_ready;
    assign phase_smp = !r_all_in;
    assign is_smp    = phase_smp && (i_op == OP_SAMPLE);
    assign proc      = acc && !(phase_smp && (i_op == OP_FLUSH));
    assign last_now  = r_all_in && (r_col == '0) && (r_row == h_next);
    assign hazard    = r_f1_v && r_f1_smp && (r_f1_col == r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_all_in <= 1'b0;
            r_emit   <= 1'b0;
            r_f1_v   <= 1'b0;
        end else begin
            r_f1_v <= proc;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[10:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default:          r_width  <= r_width;
                endcase
                r_col    <= '0;
                r_row    <= '0;
                r_all_in <= 1'b0;
                r_emit   <= 1'b0;
            end else if (proc) begin
                if (r_emit && last_now) begin
                    r_col    <= '0;
                    r_row    <= '0;
                    r_all_in <= 1'b0;
                    r_emit   <= 1'b0;
                end else begin
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 16'd1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (is_smp && col_end && (r_row == h_last)) begin
                        r_all_in <= 1'b1;
                    end
                    if ((r_row == 16'd1) && (r_col == '0)) begin
                        r_emit <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_f1_smp   <= is_smp;
            r_f1_dn    <= w_dn;
            r_f1_col   <= r_col;
            r_f1_int   <= is_smp && (r_row >= 16'd2) && (r_col >= CW'(2));
            r_f1_emit  <= r_emit;
            r_f1_last  <= last_now;
            r_f1_fwd   <= hazard;
            r_fwd_pair <= {f1_mid, r_f1_dn};
        end
    end

    // Line store: each entry holds the two older rows of one column.
    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[r_col];
        if (r_f1_v && r_f1_smp) begin
            mem[r_f1_col] <= {f1_mid, r_f1_dn};
        end
    end

    assign f1_pair = r_f1_fwd ? r_fwd_pair : r_mem_q;
    assign f1_up   = $signed(f1_pair[2*SB-1:SB]);
    assign f1_mid  = $signed(f1_pair[SB-1:0]);

    // Window order: left column up, mid, down, then centre column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_f1_v && r_f1_smp) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= f1_up;
            r_win[4] <= f1_mid;
            r_win[5] <= r_f1_dn;
        end
    end

    always_comb begin
        job.last = r_f1_last;
        if (r_f1_int) begin
            job.corners = SW'(r_win[0]) + SW'(r_win[2]) + SW'(f1_up) + SW'(r_f1_dn);
            job.d1      = SW'(r_win[3]) + SW'(r_win[5]) - SW'(r_win[4]) - SW'(r_win[4]);
            job.d2      = SW'(r_win[1]) + SW'(f1_mid) - SW'(r_win[4]) - SW'(r_win[4]);
            job.mid     = f1_mid;
            job.lm      = r_win[1];
            job.cd      = r_win[5];
            job.cu      = r_win[3];
        end else begin
            job.corners = '0;
            job.d1      = '0;
            job.d2      = '0;
            job.mid     = '0;
            job.lm      = '0;
            job.cd      = '0;
            job.cu      = '0;
        end
    end

    assign o_push = r_f1_v && r_f1_emit;
    assign o_job  = job;

endmodule

/* hw/rtl/sge_back.sv */
// Back part: stencil products, rounding, saturation and energy.
// Depends on sge_pkg; drains jobs from sge_queue into the output register.
module sge_back import sge_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [job_width(SAMPLE_BITS)-1:0] i_job,
    input  t_qstat                            i_qstat,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [17:0]                o_grad_first,
    output logic signed [17:0]                o_grad_second,
    output logic [35:0]                       o_energy,
    output logic                              o_last_pixel
);

    localparam int SB    = SAMPLE_BITS;
    localparam int SW    = SAMPLE_BITS + 3;
    localparam int ACC_W = (SAMPLE_BITS + 24 > 36) ? SAMPLE_BITS + 24 : 36;
    localparam int QW    = ACC_W - 16;

    localparam logic signed [16:0]      K_B   = signed'({1'b0, W_B});
    localparam logic signed [16:0]      K_A   = signed'({1'b0, W_A});
    localparam logic signed [16:0]      K_P   = signed'({1'b0, W_P});
    localparam logic signed [16:0]      K_M   = signed'({1'b0, W_M});
    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(32768);
    localparam logic signed [QW-1:0]    Q_MAX = QW'(OUT_MAX);
    localparam logic signed [QW-1:0]    Q_MIN = QW'(OUT_MIN);
    localparam logic signed [17:0]      G_MAX = 18'(OUT_MAX);
    localparam logic signed [17:0]      G_MIN = 18'(OUT_MIN);

    typedef struct packed {
        logic                 last;
        logic signed [SW-1:0] corners;
        logic signed [SW-1:0] d1;
        logic signed [SW-1:0] d2;
        logic signed [SB-1:0] mid;
        logic signed [SB-1:0] lm;
        logic signed [SB-1:0] cd;
        logic signed [SB-1:0] cu;
    } t_job;

    function automatic logic signed [17:0] sat_q(input logic signed [QW-1:0] q);
        if (q > Q_MAX) begin
            sat_q = G_MAX;
        end else if (q < Q_MIN) begin
            sat_q = G_MIN;
        end else begin
            sat_q = q[17:0];
        end
    endfunction

    t_job                    job;
    logic signed [SW-1:0]    j_corners;
    logic signed [SW-1:0]    j_d1;
    logic signed [SW-1:0]    j_d2;
    logic signed [SB-1:0]    j_mid;
    logic signed [SB-1:0]    j_lm;
    logic signed [SB-1:0]    j_cd;
    logic signed [SB-1:0]    j_cu;
    logic                    en;

    logic                    r_b1_v, r_b2_v, r_b3_v, r_b4_v;
    logic                    r_b1_last, r_b2_last, r_b3_last, r_b4_last;
    logic signed [ACC_W-1:0] r_pb, r_pa1, r_pa2, r_pp1, r_pm1, r_pp2, r_pm2;
    logic signed [ACC_W-1:0] r_s1, r_s2;
    logic signed [QW-1:0]    q1, q2;
    logic signed [17:0]      r_g1, r_g2, r_g1d, r_g2d;
    logic signed [35:0]      r_sq1, r_sq2;
    logic                    r_o_valid;

    assign job       = i_job;
    assign j_corners = job.corners;
    assign j_d1      = job.d1;
    assign j_d2      = job.d2;
    assign j_mid     = job.mid;
    assign j_lm      = job.lm;
    assign j_cd      = job.cd;
    assign j_cu      = job.cu;

    // The whole pipe moves together whenever the output register can take a value.
    assign en    = !r_o_valid || i_out_ready;
    assign o_pop = en && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v    <= 1'b0;
            r_b2_v    <= 1'b0;
            r_b3_v    <= 1'b0;
            r_b4_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_b1_v    <= !i_qstat.empty;
            r_b2_v    <= r_b1_v;
            r_b3_v    <= r_b2_v;
            r_b4_v    <= r_b3_v;
            r_o_valid <= r_b4_v;
        end
    end

    assign q1 = $signed(r_s1[ACC_W-1:16]);
    assign q2 = $signed(r_s2[ACC_W-1:16]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Products of the weights with the pre-summed terms.
            r_b1_last <= job.last;
            r_pb      <= j_corners * K_B;
            r_pa1     <= j_d1 * K_A;
            r_pa2     <= j_d2 * K_A;
            r_pp1     <= j_mid * K_P;
            r_pm1     <= j_lm * K_M;
            r_pp2     <= j_cd * K_P;
            r_pm2     <= j_cu * K_M;
            // Sums with the half-unit rounding offset.
            r_b2_last <= r_b1_last;
            r_s1      <= r_pb + r_pa1 + r_pp1 - r_pm1 + RND;
            r_s2      <= r_pb + r_pa2 + r_pp2 - r_pm2 + RND;
            // Floor shift by 16 bits and saturation.
            r_b3_last <= r_b2_last;
            r_g1      <= sat_q(q1);
            r_g2      <= sat_q(q2);
            // Squares.
            r_b4_last <= r_b3_last;
            r_g1d     <= r_g1;
            r_g2d     <= r_g2;
            r_sq1     <= r_g1 * r_g1;
            r_sq2     <= r_g2 * r_g2;
            // Output register.
            o_grad_first  <= r_g1d;
            o_grad_second <= r_g2d;
            o_energy      <= $unsigned(r_sq1) + $unsigned(r_sq2);
            o_last_pixel  <= r_b4_last;
        end
    end

    assign o_out_valid = r_o_valid;

endmodule

/* hw/rtl/sge_checker.sv */
// Port-level checks for the gradient energy stencil, bound to the top level.
// Depends only on the top level's ports.
module sge_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [17:0] o_grad_first,
    input logic signed [17:0] o_grad_second,
    input logic [35:0]        o_energy,
    input logic               o_last_pixel
);

    // A pending result stays offered until it is taken.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its payload.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_grad_first) && $stable(o_grad_second)
            && $stable(o_energy) && $stable(o_last_pixel))
        else $error("stalled result changed");

    // Energy is zero exactly when both gradients are zero.
    a_energy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_energy == 36'd0) == ((o_grad_first == 18'sd0) && (o_grad_second == 18'sd0))))
        else $error("energy disagrees with gradients");

    // Energy never exceeds twice the largest square.
    a_energy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_energy <= 36'd34359738368))
        else $error("energy out of range");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

endmodule

bind stencil_gradient_energy_3x3 sge_checker u_sge_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_grad_first  (o_grad_first),
    .o_grad_second (o_grad_second),
    .o_energy      (o_energy),
    .o_last_pixel  (o_last_pixel)
);

/* tb/stencil_gradient_energy_3x3_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 gradient energy stencil.
// Needs only sge_pkg and stencil_gradient_energy_3x3; it contains its own predictor of the block.
module stencil_gradient_energy_3x3_tb;
    import sge_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_COLS       = 1024;
    localparam int RANDOM_ITEMS   = 250;
    // A result leaves the block after the front part, job queue and back part; the settle
    // time leaves a comfortable margin for work still in flight on items without a result.
    localparam int SETTLE_CYCLES  = 16;
    // The longest correct quiet stretch is the settle time plus a run of random
    // stalls on either side; at a stall rate of 79 per cent a run of even a hundred
    // is practically impossible, so two thousand quiet cycles means a hang.
    localparam int WATCHDOG_LIMIT = 2000;

    // Stencil weights widened once for the predictor's arithmetic.
    localparam longint KB = W_B;
    localparam longint KA = W_A;
    localparam longint KP = W_P;
    localparam longint KM = W_M;

    typedef struct packed {
        logic signed [17:0] grad_first;
        logic signed [17:0] grad_second;
        logic [35:0]        energy;
        logic               last_pixel;
    } t_grad_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    // How a directed row is checked: no result allowed, a result typed into the
    // table, or whatever the predictor works out.
    typedef enum logic [1:0] {CHK_NONE, CHK_FIXED, CHK_MODEL} t_check;

    typedef struct packed {
        t_row_kind    kind;
        logic         op;
        logic [15:0]  value;
        logic         cfg_idx;
        t_check       chk;
        t_grad_result want;
    } t_dir_row;

    localparam t_grad_result ZERO_RES  = '0;
    localparam t_grad_result ZERO_LAST = '{18'sd0, 18'sd0, 36'd0, 1'b1};

    localparam int DIR_ROWS = 27;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Two samples under the reset geometry (1024 x 1024): far too early for a result.
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h8000, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        // A 3 x 3 frame has exactly one interior pixel; the write aborts the frame above.
        '{ROW_CFG,  OP_SAMPLE, 16'd3,    REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_CFG,  OP_SAMPLE, 16'd3,    REG_IMAGE_HEIGHT, CHK_NONE,  ZERO_RES},
        // A flush before the frame is full is ignored altogether.
        '{ROW_ITEM, OP_FLUSH,  16'h1234, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        // Checkerboard of the sample extremes.
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h8000, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h8000, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h8000, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h8000, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_MODEL, ZERO_RES},
        // Frame full: samples now count as flush ticks and their data is dropped.
        '{ROW_ITEM, OP_SAMPLE, 16'h7FFF, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_FLUSH,  16'h0000, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'hFFFF, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_RES},
        '{ROW_ITEM, OP_FLUSH,  16'h5A5A, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_LAST},
        // A fresh frame, cut short by the next register write.
        '{ROW_ITEM, OP_SAMPLE, 16'h5555, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'hAAAA, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h0001, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'hFFFE, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        // Zero in either register behaves as one: a single-pixel frame.
        '{ROW_CFG,  OP_SAMPLE, 16'd0,    REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_CFG,  OP_SAMPLE, 16'd0,    REG_IMAGE_HEIGHT, CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h8001, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_FLUSH,  16'h0000, REG_IMAGE_WIDTH,  CHK_NONE,  ZERO_RES},
        '{ROW_ITEM, OP_SAMPLE, 16'h4000, REG_IMAGE_WIDTH,  CHK_FIXED, ZERO_LAST}
    };

    // Block ports.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               i_op = OP_SAMPLE;
    logic signed [15:0] i_sample = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = REG_IMAGE_WIDTH;
    logic [15:0]        i_cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [17:0] o_grad_first;
    logic signed [17:0] o_grad_second;
    logic [35:0]        o_energy;
    logic               o_last_pixel;

    // Predictor state: its own line stores, window, raster position and registers.
    shortint     line_up [MAX_COLS];
    shortint     line_mid [MAX_COLS];
    shortint     win [6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned frame_items = 0;
    logic [10:0] cfg_width = WIDTH_RESET;
    logic [15:0] cfg_height = HEIGHT_RESET;

    t_grad_result grad_expect_q [$];
    t_grad_result head_res;

    int unsigned send_gap_pct = 19;
    int unsigned recv_stall_pct = 79;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned counted_items = 0;
    int unsigned frames_run = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;

    stencil_gradient_energy_3x3 #(
        .MAX_WIDTH   (MAX_COLS),
        .SAMPLE_BITS (16)
    ) u_top (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Effective frame geometry after the block's clamping of the registers.
    function automatic void frame_dims(output int unsigned w, output int unsigned h);
        w = (cfg_width == 11'd0) ? 1 : (cfg_width > MAX_COLS) ? MAX_COLS : cfg_width;
        h = (cfg_height == 16'd0) ? 1 : cfg_height;
    endfunction

    // Round half up by 16 bits, then clamp to the 18-bit output range.
    function automatic longint round_q16(input longint acc);
        longint q;
        q = (acc + 32768) >>> 16;
        if (q > OUT_MAX) q = OUT_MAX;
        else if (q < OUT_MIN) q = OUT_MIN;
        return q;
    endfunction

    // Advances the predictor by one accepted input transaction and returns 1 when
    // that transaction releases a result, which is then placed in res.
    function automatic bit gradient_predict(input logic op, input logic [15:0] smp,
                                            output t_grad_result res);
        int unsigned w, h, total, n;
        longint up, mid, dn, lu, lm, ld, cu, cm, cd, acc1, acc2, g1, g2;
        frame_dims(w, h);
        total = w * h;
        n = frame_items;
        res = '0;
        g1 = 0;
        g2 = 0;
        if (n < total) begin
            // Until the frame is full a flush changes nothing at all.
            if (op == OP_FLUSH) return 1'b0;
            dn = shortint'(smp);
            up = line_up[col_pos];
            mid = line_mid[col_pos];
            line_up[col_pos] = line_mid[col_pos];
            line_mid[col_pos] = shortint'(smp);
            if (row_pos >= 2 && row_pos + 1 <= h && col_pos >= 2 && col_pos + 1 <= w) begin
                lu = win[0];
                lm = win[1];
                ld = win[2];
                cu = win[3];
                cm = win[4];
                cd = win[5];
                acc1 = KB * (lu + ld + up + dn) + KA * (cu + cd - 2 * cm) + KP * mid - KM * lm;
                acc2 = KB * (lu + ld + up + dn) + KA * (lm + mid - 2 * cm) + KP * cd - KM * cu;
                g1 = round_q16(acc1);
                g2 = round_q16(acc2);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = shortint'(up);
            win[4] = shortint'(mid);
            win[5] = shortint'(dn);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 32'hFFFF;
        end
        frame_items = n + 1;
        // Results trail the input by one row plus one pixel.
        if (n < w + 1) return 1'b0;
        res.grad_first = 18'(g1);
        res.grad_second = 18'(g2);
        res.energy = 36'(g1 * g1 + g2 * g2);
        res.last_pixel = (n == total + w);
        if (res.last_pixel) begin
            col_pos = 0;
            row_pos = 0;
            frame_items = 0;
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t ns] %s: got %0d, expected %0d (result %0d)",
                 $time, field, got, want, results_checked);
        mismatches++;
    endtask

    // Presents one input transaction, waits for it to be taken and runs the predictor.
    // Valid is only dropped for a random gap or while results are drained, never between back-to-back items.
    task automatic send_item(input logic op, input logic [15:0] smp, input bit model_checked);
        t_grad_result res;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_sample <= smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (gradient_predict(op, smp, res) && model_checked) grad_expect_q.push_back(res);
    endtask

    // Holds the input side idle until every expected result has arrived, then lets
    // the pipeline run dry.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (grad_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle; each one aborts the frame.
    task automatic write_reg(input logic idx, input logic [15:0] data);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) cfg_width = data[10:0];
        else cfg_height = data;
        col_pos = 0;
        row_pos = 0;
        frame_items = 0;
    endtask

    // Streams one frame under the current geometry: n_samples samples with the odd
    // premature flush mixed in, then, for a complete frame, the W+1 draining ticks.
    task automatic stream_frame(input int unsigned n_samples, input bit with_ticks,
                                input bit allow_pause);
        int unsigned w, h, pause_at;
        frame_dims(w, h);
        pause_at = (allow_pause && n_samples > 0) ? $urandom_range(n_samples - 1) : n_samples;
        for (int unsigned k = 0; k < n_samples; k++) begin
            if (k == pause_at) drain_results();
            if ($urandom_range(11) == 0) send_item(OP_FLUSH, 16'($urandom), 1'b1);
            send_item(OP_SAMPLE, pick_sample(), 1'b1);
            counted_items++;
        end
        if (with_ticks) begin
            for (int unsigned k = 0; k < w + 1; k++) begin
                send_item(1'($urandom_range(1)), 16'($urandom), 1'b1);
                counted_items++;
            end
        end
    endtask

    // Result side: random back-pressure and a field-by-field comparison with the
    // oldest outstanding expectation.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grad_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected", 1, 0);
            end else begin
                head_res = grad_expect_q.pop_front();
                if (o_grad_first !== head_res.grad_first)
                    report_mismatch("grad_first", o_grad_first, head_res.grad_first);
                if (o_grad_second !== head_res.grad_second)
                    report_mismatch("grad_second", o_grad_second, head_res.grad_second);
                if (o_energy !== head_res.energy)
                    report_mismatch("energy", o_energy, head_res.energy);
                if (o_last_pixel !== head_res.last_pixel)
                    report_mismatch("last_pixel", o_last_pixel, head_res.last_pixel);
                results_checked++;
            end
        end
    end

    // Any cycle without a transaction on either channel counts towards a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, grad_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int unsigned w_val, h_val, w, h;
        bit abort, need_cfg;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: walk the table.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_reg(DIRECTED[r].cfg_idx, DIRECTED[r].value);
            end else begin
                send_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].chk == CHK_MODEL);
                if (DIRECTED[r].chk == CHK_FIXED) grad_expect_q.push_back(DIRECTED[r].want);
            end
        end

        // Random part: mostly complete frames of small random geometry, some of them
        // back to back with no register write, some cut short by one.
        need_cfg = 1'b1;
        while (counted_items < RANDOM_ITEMS) begin
            if (counted_items < RANDOM_ITEMS / 3) begin
                send_gap_pct = 19;
                recv_stall_pct = 79;
            end else if (counted_items < 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct = 79;
                recv_stall_pct = 19;
            end else begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            if (need_cfg || $urandom_range(3) != 0) begin
                case ($urandom_range(19))
                    0: w_val = 0;
                    1: w_val = 1;
                    2, 3: w_val = $urandom_range(9, 24);
                    default: w_val = $urandom_range(2, 8);
                endcase
                h_val = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
                write_reg(REG_IMAGE_WIDTH, 16'(w_val));
                write_reg(REG_IMAGE_HEIGHT, 16'(h_val));
            end
            frame_dims(w, h);
            abort = ($urandom_range(7) == 0);
            // The first frame always includes a pause that drains every result, unless it has no samples.
            stream_frame(abort ? $urandom_range(w * h - 1) : w * h, !abort,
                         frames_run == 0 || $urandom_range(9) == 0);
            need_cfg = abort;
            frames_run++;
        end

        // The largest geometries, once each: a width above the limit, taken as the
        // full 1024 columns and cut short just after the first column wrap, then the
        // tallest frame, also cut short.
        write_reg(REG_IMAGE_WIDTH, 16'd2047);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        stream_frame(1028, 1'b0, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'd65535);
        stream_frame(40, 1'b0, 1'b0);

        drain_results();
        $display("Sent %0d input transactions: %0d directed rows, %0d random frames, %s",
                 items_sent, DIR_ROWS, frames_run, "then clamped-width and tallest frames.");
        $display("Compared %0d results field by field; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
